>>> hdl/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg: shared constants and types for the TRR segment intersect block
// Coordinate width, fraction bits and result kind codes.
// ----------------------------------------------------------------------------
package trr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 2;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_PIECE  = 2'd2,
        KIND_INSIDE = 2'd3
    } t_kind;

endpackage

>>> hdl/trr_side_meet.sv
// ----------------------------------------------------------------------------
// trr_side_meet: meet one diamond side with a Manhattan arc
// Side and arc are given by line intercepts (doubled-free) and y extents.
// ----------------------------------------------------------------------------
module trr_side_meet #(
    parameter int W = 28
) (
    input  logic               i_side_pos,
    input  logic signed [W-1:0] i_side_b,
    input  logic signed [W-1:0] i_side_lo_x,
    input  logic signed [W-1:0] i_side_lo_y,
    input  logic signed [W-1:0] i_side_hi_x,
    input  logic signed [W-1:0] i_side_hi_y,
    input  logic               i_arc_pt,
    input  logic               i_arc_pos,
    input  logic signed [W-1:0] i_arc_b,
    input  logic signed [W-1:0] i_arc_lo_x,
    input  logic signed [W-1:0] i_arc_lo_y,
    input  logic signed [W-1:0] i_arc_hi_x,
    input  logic signed [W-1:0] i_arc_hi_y,
    output trr_pkg::t_kind     o_kind,
    output logic signed [W-1:0] o_lo_x,
    output logic signed [W-1:0] o_lo_y,
    output logic signed [W-1:0] o_hi_x,
    output logic signed [W-1:0] o_hi_y
);

    logic signed [W:0] pt_line;
    logic signed [W:0] p_b;
    logic signed [W:0] m_b;
    logic signed [W:0] y2;
    logic signed [W:0] x2;
    logic signed [W-1:0] lo_x, lo_y, hi_x, hi_y;

    always_comb begin
        o_kind = trr_pkg::KIND_NONE;
        o_lo_x = '0;
        o_lo_y = '0;
        o_hi_x = '0;
        o_hi_y = '0;
        pt_line = i_side_pos ? ({i_arc_lo_y[W-1], i_arc_lo_y} - {i_arc_lo_x[W-1], i_arc_lo_x})
                             : ({i_arc_lo_y[W-1], i_arc_lo_y} + {i_arc_lo_x[W-1], i_arc_lo_x});
        p_b = i_side_pos ? {i_side_b[W-1], i_side_b} : {i_arc_b[W-1], i_arc_b};
        m_b = i_side_pos ? {i_arc_b[W-1], i_arc_b} : {i_side_b[W-1], i_side_b};
        y2  = m_b + p_b;
        x2  = m_b - p_b;
        hi_x = (i_arc_hi_y < i_side_hi_y) ? i_arc_hi_x : i_side_hi_x;
        hi_y = (i_arc_hi_y < i_side_hi_y) ? i_arc_hi_y : i_side_hi_y;
        lo_x = (i_arc_lo_y > i_side_lo_y) ? i_arc_lo_x : i_side_lo_x;
        lo_y = (i_arc_lo_y > i_side_lo_y) ? i_arc_lo_y : i_side_lo_y;
        if (i_arc_pt) begin
            if (pt_line == {i_side_b[W-1], i_side_b} && i_side_lo_y <= i_arc_lo_y
                    && i_arc_lo_y <= i_side_hi_y) begin
                o_kind = trr_pkg::KIND_POINT;
                o_lo_x = i_arc_lo_x;
                o_lo_y = i_arc_lo_y;
                o_hi_x = i_arc_lo_x;
                o_hi_y = i_arc_lo_y;
            end
        end else if (i_side_pos == i_arc_pos) begin
            if (i_side_b == i_arc_b && !(hi_y < lo_y)) begin
                o_kind = (lo_x == hi_x && lo_y == hi_y) ? trr_pkg::KIND_POINT
                                                        : trr_pkg::KIND_PIECE;
                o_lo_x = lo_x;
                o_lo_y = lo_y;
                o_hi_x = hi_x;
                o_hi_y = hi_y;
            end
        end else begin
            if (signed'({i_side_lo_y, 1'b0}) <= y2 && y2 <= signed'({i_side_hi_y, 1'b0})
                    && signed'({i_arc_lo_y, 1'b0}) <= y2
                    && y2 <= signed'({i_arc_hi_y, 1'b0})) begin
                // arithmetic shift floors the halving
                o_kind = trr_pkg::KIND_POINT;
                o_lo_x = x2[W:1];
                o_lo_y = y2[W:1];
                o_hi_x = x2[W:1];
                o_hi_y = y2[W:1];
            end
        end
    end

endmodule

>>> hdl/trr_segment_intersect.sv
// ----------------------------------------------------------------------------
// trr_segment_intersect: diamond (TRR) against Manhattan arc intersection
// Slave channel takes one query word, master channel returns one result word.
// Each query passes two register stages: input register, result register.
// One query per cycle while the receiver keeps up; all four sides are tested
// in parallel by combinational logic between the two register stages and the
// first hit in side order wins.
// Reset clears both valid flags; data registers are not reset.
// When the receiver stalls, the result register holds its word; the input
// stage keeps accepting while either stage has room, so the pipeline
// advances whenever the result register empties or is being taken.
// s tdata (lowest bit up): center_x, center_y, radius, arc_low_x,
// arc_low_y, arc_high_x, arc_high_y.
// m tdata (lowest bit up): kind, res_low_x, res_low_y, res_high_x,
// res_high_y.
// ----------------------------------------------------------------------------
module trr_segment_intersect #(
    parameter int COORD_WIDTH = trr_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = trr_pkg::FRAC_BITS,
    localparam int RW  = COORD_WIDTH - 2,
    localparam int IW  = 6 * COORD_WIDTH + RW,
    localparam int IWB = ((IW + 7) / 8) * 8,
    localparam int OW  = 2 + 4 * COORD_WIDTH,
    localparam int OWB = ((OW + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // center_x, center_y, radius, arc_low_x, arc_low_y, arc_high_x, arc_high_y
    input  logic [IWB-1:0] s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // kind, res_low_x, res_low_y, res_high_x, res_high_y
    output logic [OWB-1:0] m_axis_tdata
);

    localparam int C = COORD_WIDTH;
    localparam int W = C + 4;

    logic           r_in_vld;
    logic [IW-1:0]  r_in;
    logic           r_out_vld;
    logic [OW-1:0]  r_out;
    logic           adv;

    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || adv;

    logic signed [W-1:0] cx, cy, r, ax0, ay0, ax1, ay1;
    logic signed [W-1:0] lx, ly, hx, hy, ddx, ddy, ab, cb;
    logic                arc_pt, arc_pos, bad, hit0;
    logic signed [W-1:0] vx [4];
    logic signed [W-1:0] vy [4];
    logic                spos [4];
    logic signed [W-1:0] sb [4], slx [4], sly [4], shx [4], shy [4];
    trr_pkg::t_kind      mk [4];
    logic signed [W-1:0] mlx [4], mly [4], mhx [4], mhy [4];
    logic signed [W-1:0] adx0, ady0, adx1, ady1;
    logic                in0, in1;
    trr_pkg::t_kind      kind;
    logic signed [W-1:0] olx, oly, ohx, ohy;

    always_comb begin
        cx  = W'(signed'(r_in[C-1:0]));
        cy  = W'(signed'(r_in[2*C-1:C]));
        r   = W'({1'b0, r_in[2*C+RW-1:2*C]});
        ax0 = W'(signed'(r_in[3*C+RW-1:2*C+RW]));
        ay0 = W'(signed'(r_in[4*C+RW-1:3*C+RW]));
        ax1 = W'(signed'(r_in[5*C+RW-1:4*C+RW]));
        ay1 = W'(signed'(r_in[6*C+RW-1:5*C+RW]));
        if (ay0 > ay1) begin
            lx = ax1; ly = ay1; hx = ax0; hy = ay0;
        end else begin
            lx = ax0; ly = ay0; hx = ax1; hy = ay1;
        end
        ddx     = hx - lx;
        ddy     = hy - ly;
        arc_pt  = (ddx == '0) && (ddy == '0);
        arc_pos = (ddy > 0) && (ddx == ddy);
        bad     = !arc_pt && !arc_pos && !((ddy > 0) && (ddx == -ddy));
        ab      = arc_pos ? (ly - lx) : (ly + lx);
        cb      = arc_pos ? (cy - cx) : (cy + cx);
        hit0    = arc_pt ? (lx == cx && ly == cy)
                         : (cb == ab && ly <= cy && cy <= hy);
        vx[0] = cx;     vy[0] = cy - r;
        vx[1] = cx + r; vy[1] = cy;
        vx[2] = cx;     vy[2] = cy + r;
        vx[3] = cx - r; vy[3] = cy;
        spos[0] = 1'b1; slx[0] = vx[0]; sly[0] = vy[0]; shx[0] = vx[1]; shy[0] = vy[1];
        spos[1] = 1'b0; slx[1] = vx[1]; sly[1] = vy[1]; shx[1] = vx[2]; shy[1] = vy[2];
        spos[2] = 1'b1; slx[2] = vx[3]; sly[2] = vy[3]; shx[2] = vx[2]; shy[2] = vy[2];
        spos[3] = 1'b0; slx[3] = vx[0]; sly[3] = vy[0]; shx[3] = vx[3]; shy[3] = vy[3];
        for (int i = 0; i < 4; i++) begin
            sb[i] = spos[i] ? (sly[i] - slx[i]) : (sly[i] + slx[i]);
        end
        adx0 = (lx < cx) ? cx - lx : lx - cx;
        ady0 = (ly < cy) ? cy - ly : ly - cy;
        adx1 = (hx < cx) ? cx - hx : hx - cx;
        ady1 = (hy < cy) ? cy - hy : hy - cy;
        in0  = (adx0 + ady0) <= r;
        in1  = (adx1 + ady1) <= r;
    end

    for (genvar g = 0; g < 4; g++) begin : g_side
        trr_side_meet #(.W(W)) u_meet (
            .i_side_pos (spos[g]),
            .i_side_b   (sb[g]),
            .i_side_lo_x(slx[g]),
            .i_side_lo_y(sly[g]),
            .i_side_hi_x(shx[g]),
            .i_side_hi_y(shy[g]),
            .i_arc_pt   (arc_pt),
            .i_arc_pos  (arc_pos),
            .i_arc_b    (ab),
            .i_arc_lo_x (lx),
            .i_arc_lo_y (ly),
            .i_arc_hi_x (hx),
            .i_arc_hi_y (hy),
            .o_kind     (mk[g]),
            .o_lo_x     (mlx[g]),
            .o_lo_y     (mly[g]),
            .o_hi_x     (mhx[g]),
            .o_hi_y     (mhy[g])
        );
    end

    always_comb begin
        kind = trr_pkg::KIND_NONE;
        olx = '0; oly = '0; ohx = '0; ohy = '0;
        if (bad) begin
            kind = trr_pkg::KIND_NONE;
        end else if (r == '0) begin
            if (hit0) begin
                kind = trr_pkg::KIND_POINT;
                olx = cx; oly = cy; ohx = cx; ohy = cy;
            end
        end else if (mk[0] != trr_pkg::KIND_NONE) begin
            kind = mk[0]; olx = mlx[0]; oly = mly[0]; ohx = mhx[0]; ohy = mhy[0];
        end else if (mk[1] != trr_pkg::KIND_NONE) begin
            kind = mk[1]; olx = mlx[1]; oly = mly[1]; ohx = mhx[1]; ohy = mhy[1];
        end else if (mk[2] != trr_pkg::KIND_NONE) begin
            kind = mk[2]; olx = mlx[2]; oly = mly[2]; ohx = mhx[2]; ohy = mhy[2];
        end else if (mk[3] != trr_pkg::KIND_NONE) begin
            kind = mk[3]; olx = mlx[3]; oly = mly[3]; ohx = mhx[3]; ohy = mhy[3];
        end else if (in0 && in1) begin
            kind = trr_pkg::KIND_INSIDE;
            olx = lx; oly = ly; ohx = hx; ohy = hy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= s_axis_tdata[IW-1:0];
        end
        if (adv && r_in_vld) begin
            r_out <= {ohy[C-1:0], ohx[C-1:0], oly[C-1:0], olx[C-1:0], kind};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OWB'(r_out);

    // fraction bits only scale the grid; no decision depends on them
    logic unused_frac;
    assign unused_frac = (FRAC_BITS < 0);

endmodule

>>> sim/trr_segment_intersect_checker.sv
// ----------------------------------------------------------------------------
// trr_segment_intersect_checker: result predictor and scoreboard
// Watches both stream channels, computes the expected result word for each
// accepted query and compares the returned words field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trr_segment_intersect_checker #(
    parameter int IWB = 168,
    parameter int OWB = 104
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tready,
    input  logic [IWB-1:0] i_s_tdata,
    input  logic           i_m_tvalid,
    input  logic           i_m_tready,
    input  logic [OWB-1:0] i_m_tdata,
    output int             o_errors,
    output int             o_pending
);

    localparam int CW = trr_pkg::COORD_WIDTH;
    localparam int RW = CW - 2;

    typedef struct {
        trr_pkg::t_kind       kind;
        logic signed [CW-1:0] lx, ly, hx, hy;
    } t_hit;

    typedef struct {
        longint x, y;
    } t_pt;

    typedef struct {
        bit     up;    // slope +1 when set
        longint b;
        t_pt    lo, hi;
    } t_seg;

    t_hit hit_queue[$];

    function automatic bit pt_on(t_seg s, t_pt p);
        return s.up ? (p.y - p.x == s.b) : (p.y + p.x == s.b);
    endfunction

    function automatic t_seg side_of(bit up, t_pt lo, t_pt hi);
        t_seg s;
        s.up = up;
        s.lo = lo;
        s.hi = hi;
        s.b  = up ? lo.y - lo.x : lo.y + lo.x;
        return s;
    endfunction

    function automatic longint half_down(longint v);
        return (v - (v & 1)) / 2;
    endfunction

    function automatic bit within_diamond(t_pt c, longint r, t_pt p);
        longint dx, dy;
        dx = p.x - c.x;
        dy = p.y - c.y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return dx + dy <= r;
    endfunction

    // Meet one diamond side with the arc: 0 none, 1 point, 2 piece.
    function automatic int side_meet(t_seg s, bit is_pt, t_seg a, ref t_pt rlo, ref t_pt rhi);
        t_pt lo, hi;
        longint p, m, y2, x2;
        if (is_pt) begin
            if (pt_on(s, a.lo) && s.lo.y <= a.lo.y && a.lo.y <= s.hi.y) begin
                rlo = a.lo;
                rhi = a.lo;
                return 1;
            end
            return 0;
        end
        if (s.up == a.up) begin
            if (s.b != a.b) return 0;
            hi = (a.hi.y < s.hi.y) ? a.hi : s.hi;
            lo = (a.lo.y > s.lo.y) ? a.lo : s.lo;
            if (hi.y < lo.y) return 0;
            rlo = lo;
            rhi = hi;
            return (lo.x == hi.x && lo.y == hi.y) ? 1 : 2;
        end
        p  = s.up ? s.b : a.b;
        m  = s.up ? a.b : s.b;
        y2 = m + p;
        x2 = m - p;
        if (2 * s.lo.y <= y2 && y2 <= 2 * s.hi.y && 2 * a.lo.y <= y2 && y2 <= 2 * a.hi.y) begin
            rlo.x = half_down(x2);
            rlo.y = half_down(y2);
            rhi = rlo;
            return 1;
        end
        return 0;
    endfunction

    function automatic t_hit predict_hit(logic [IWB-1:0] d);
        t_hit   h;
        t_pt    c, rlo, rhi, tmp, v0, v1, v2, v3;
        t_seg   a;
        t_seg   sides[4];
        longint r, dx, dy;
        bit     is_pt;
        int     k;
        c.x    = longint'($signed(d[0*CW +: CW]));
        c.y    = longint'($signed(d[1*CW +: CW]));
        r      = longint'(d[2*CW +: RW]);
        a.lo.x = longint'($signed(d[2*CW+RW +: CW]));
        a.lo.y = longint'($signed(d[3*CW+RW +: CW]));
        a.hi.x = longint'($signed(d[4*CW+RW +: CW]));
        a.hi.y = longint'($signed(d[5*CW+RW +: CW]));
        if (a.lo.y > a.hi.y) begin
            tmp  = a.lo;
            a.lo = a.hi;
            a.hi = tmp;
        end
        rlo = '{0, 0};
        rhi = '{0, 0};
        is_pt = 0;
        k = 0;
        a.up = 0;
        a.b = 0;
        dx = a.hi.x - a.lo.x;
        dy = a.hi.y - a.lo.y;
        if (dx == 0 && dy == 0) begin
            is_pt = 1;
        end else if (dy > 0 && dx == dy) begin
            a.up = 1;
            a.b  = a.lo.y - a.lo.x;
        end else if (dy > 0 && dx == -dy) begin
            a.b = a.lo.y + a.lo.x;
        end else begin
            k = -1;
        end
        if (k == 0 && r == 0) begin
            if (is_pt ? (a.lo.x == c.x && a.lo.y == c.y)
                      : (pt_on(a, c) && a.lo.y <= c.y && c.y <= a.hi.y)) begin
                k = 1;
                rlo = c;
                rhi = c;
            end
        end else if (k == 0) begin
            v0 = '{c.x, c.y - r};
            v1 = '{c.x + r, c.y};
            v2 = '{c.x, c.y + r};
            v3 = '{c.x - r, c.y};
            sides[0] = side_of(1, v0, v1);
            sides[1] = side_of(0, v1, v2);
            sides[2] = side_of(1, v3, v2);
            sides[3] = side_of(0, v0, v3);
            for (int i = 0; i < 4 && k == 0; i++)
                k = side_meet(sides[i], is_pt, a, rlo, rhi);
            if (k == 0 && within_diamond(c, r, a.lo) && within_diamond(c, r, a.hi)) begin
                k = 3;
                rlo = a.lo;
                rhi = a.hi;
            end
        end
        if (k <= 0) begin
            k = 0;
            rlo = '{0, 0};
            rhi = '{0, 0};
        end
        h.kind = trr_pkg::t_kind'(k[1:0]);
        h.lx = rlo.x[CW-1:0];
        h.ly = rlo.y[CW-1:0];
        h.hx = rhi.x[CW-1:0];
        h.hy = rhi.y[CW-1:0];
        return h;
    endfunction

    always @(posedge i_clk) begin
        t_hit want, got;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                hit_queue = {hit_queue, predict_hit(i_s_tdata)};
            if (i_m_tvalid && i_m_tready) begin
                got.kind = trr_pkg::t_kind'(i_m_tdata[1:0]);
                got.lx   = i_m_tdata[2 +: CW];
                got.ly   = i_m_tdata[2+CW +: CW];
                got.hx   = i_m_tdata[2+2*CW +: CW];
                got.hy   = i_m_tdata[2+3*CW +: CW];
                if (hit_queue.size() == 0) begin
                    $display("%0t: unexpected result word kind=%0d", $time, got.kind);
                    o_errors <= o_errors + 1;
                end else begin
                    want = hit_queue.pop_front();
                    if (want.kind != got.kind || want.lx != got.lx || want.ly != got.ly ||
                        want.hx != got.hx || want.hy != got.hy) begin
                        $display("%0t: mismatch expected %0d (%0d,%0d)-(%0d,%0d) got %0d (%0d,%0d)-(%0d,%0d)",
                                 $time, want.kind, want.lx, want.ly, want.hx, want.hy,
                                 got.kind, got.lx, got.ly, got.hx, got.hy);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= hit_queue.size();
        end
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: TRR segment intersect stimulus and verdict
// Drives directed and random diamond/arc queries under several idling
// phases; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int CW  = trr_pkg::COORD_WIDTH;
    localparam int RW  = CW - 2;
    localparam int IWB = ((6 * CW + RW + 7) / 8) * 8;
    localparam int OWB = ((2 + 4 * CW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int CMAX = (1 << (CW - 1)) - 1;
    localparam int CMIN = -(1 << (CW - 1));
    localparam int RMAX = (1 << RW) - 1;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [IWB-1:0] s_axis_tdata;  // center_x, center_y, radius, arc lo x/y, arc hi x/y
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [OWB-1:0] m_axis_tdata;  // kind, res_low_x, res_low_y, res_high_x, res_high_y

    int errors;
    int pending;
    int send_idle;
    int recv_stall;
    int cycles;

    trr_segment_intersect DUT (.*);

    trr_segment_intersect_checker #(.IWB(IWB), .OWB(OWB)) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver stalls at random with the current phase's percentage.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic [IWB-1:0] pack_query(int cx, int cy, int r, int lx, int ly,
                                                  int hx, int hy);
        logic [IWB-1:0] d;
        d = '0;
        d[0*CW +: CW]    = cx[CW-1:0];
        d[1*CW +: CW]    = cy[CW-1:0];
        d[2*CW +: RW]    = r[RW-1:0];
        d[2*CW+RW +: CW] = lx[CW-1:0];
        d[3*CW+RW +: CW] = ly[CW-1:0];
        d[4*CW+RW +: CW] = hx[CW-1:0];
        d[5*CW+RW +: CW] = hy[CW-1:0];
        return d;
    endfunction

    // Hold valid after the accepting edge; the next word or drain takes over.
    task automatic send_query(logic [IWB-1:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Small coordinates near a random origin give frequent hits.
    task automatic send_random();
        int cx, cy, r, lx, ly, len, sel, hx, hy;
        sel = $urandom_range(9);
        if (sel == 0) begin
            send_query(IWB'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
            return;
        end
        cx = $urandom_range(1, 0) ? $signed($urandom) >>> 9 : $urandom_range(40) - 20;
        cy = $urandom_range(1, 0) ? $signed($urandom) >>> 9 : $urandom_range(40) - 20;
        r  = (sel == 1) ? $urandom_range(RMAX) : $urandom_range(24);
        if ($urandom_range(7) == 0) r = 0;
        lx = cx + $urandom_range(60) - 30;
        ly = cy + $urandom_range(60) - 30;
        len = $urandom_range(1) ? $urandom_range(40) : 0;
        hx = lx + (($urandom_range(1)) ? len : -len);
        hy = ly + len;
        if (sel == 2) hx = hx + $urandom_range(2) - 1;
        if ($urandom_range(3) == 0) begin
            send_query(pack_query(cx, cy, r, hx, hy, lx, ly));
        end else begin
            send_query(pack_query(cx, cy, r, lx, ly, hx, hy));
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 0;
        s_axis_tvalid <= 0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 0;
        send_idle     = 0;
        recv_stall    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // slope +1 crossing, slope -1 crossing, parallel miss, point overlap, collinear through a vertex
        send_query(pack_query(0, 0, 8, -10, -2, 10, 18));
        send_query(pack_query(0, 0, 8, 10, -2, -10, 18));
        send_query(pack_query(0, 0, 8, 2, -8, 12, 2));
        send_query(pack_query(0, 0, 8, 8, 0, 12, 4));
        send_query(pack_query(0, 0, 7, -10, -3, 10, 17));
        // whole arc inside, point arc on side / inside / outside
        send_query(pack_query(0, 0, 8, -2, -2, 2, 2));
        send_query(pack_query(0, 0, 8, 4, 4, 4, 4));
        send_query(pack_query(0, 0, 8, 1, 1, 1, 1));
        send_query(pack_query(0, 0, 8, 9, 9, 9, 9));
        // swapped endpoints, wrong shapes
        send_query(pack_query(0, 0, 8, 10, 18, -10, -2));
        send_query(pack_query(0, 0, 8, -5, 0, 5, 0));
        send_query(pack_query(0, 0, 8, 0, -5, 0, 5));
        send_query(pack_query(0, 0, 8, 0, 0, 3, 6));
        // zero radius: on arc, off arc, point equal
        send_query(pack_query(3, 3, 0, 0, 0, 6, 6));
        send_query(pack_query(3, 4, 0, 0, 0, 6, 6));
        send_query(pack_query(3, 3, 0, 3, 3, 3, 3));
        // extremes and ignored padding bits
        send_query(pack_query(CMAX, CMAX, RMAX, CMIN, CMIN, CMAX, CMAX));
        send_query(pack_query(CMIN, CMIN, RMAX, CMAX, CMIN, CMIN, CMAX));
        send_query(pack_query(0, 0, RMAX, CMIN, CMIN, CMIN, CMIN));
        send_query({IWB{1'b1}});
        send_query('0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1) ? 50 : (ph == 3) ? 35 : 0;
            recv_stall = (ph == 2) ? 50 : (ph == 3) ? 35 : 0;
            repeat (500) send_random();
        end
        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/trr_pkg.sv
hdl/trr_side_meet.sv
hdl/trr_segment_intersect.sv
sim/trr_segment_intersect_checker.sv
sim/testbench.sv
